FILE: design/sfb_pkg.sv
package sfb_pkg;

	localparam int unsigned WinDepth  = 16;
	localparam int unsigned SampleW   = 10;
	localparam int unsigned DataW     = 16;
	localparam int unsigned FracBits  = 10;
	localparam int unsigned ThrW      = 4;
	localparam logic [ThrW-1:0] ThrReset = 4'd11;

	// operand address space: 16 window slots, then scratch, magnitudes and zero
	localparam int unsigned RegW = 6;

	// twiddle constants (Q5.10)
	localparam logic [DataW-1:0] K_SIN2 = 16'd391;
	localparam logic [DataW-1:0] K_SIN4 = 16'd724;
	localparam logic [DataW-1:0] K_SIN6 = 16'd946;
	localparam logic [DataW-1:0] K_CPS  = 16'd1337;
	localparam logic [DataW-1:0] K_CMS2 = 16'd554;
	localparam logic [DataW-1:0] K_CMS6 = 16'hFDD6;

	// datapath operations
	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,  // d = a + b
		OP_SUB  = 3'd1,  // d = a - b
		OP_SUB2 = 3'd2,  // d = a - b - b
		OP_MULK = 3'd3,  // d = a * k
		OP_MUL  = 3'd4,  // d = a * b
		OP_NSUB = 3'd5,  // d = -a - b
		OP_END  = 3'd6
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [RegW-1:0] a;
		logic [RegW-1:0] b;
		logic [RegW-1:0] d;
		logic [2:0]      k;
	} uinst_t;

	localparam logic [2:0] KS2 = 3'd0;
	localparam logic [2:0] KS4 = 3'd1;
	localparam logic [2:0] KS6 = 3'd2;
	localparam logic [2:0] KCP = 3'd3;
	localparam logic [2:0] KM2 = 3'd4;
	localparam logic [2:0] KM6 = 3'd5;

	function automatic logic [DataW-1:0] kval(input logic [2:0] k);
		logic [DataW-1:0] r;
		unique case (k)
			KS2:     r = K_SIN2;
			KS4:     r = K_SIN4;
			KS6:     r = K_SIN6;
			KCP:     r = K_CPS;
			KM2:     r = K_CMS2;
			KM6:     r = K_CMS6;
			default: r = '0;
		endcase
		return r;
	endfunction

	// register names: x0..x15 = 0..15, t0..t15 = 16..31, y0..y15 = 32..47,
	// m0..m7 = 48..55, zero 56 (reads as zero, never written)
	localparam int unsigned T0 = 16;
	localparam int unsigned Y0 = 32;
	localparam int unsigned M0 = 48;
	localparam int unsigned ZR = 56;
	// scratch: y0 is free during the complex twiddles, t8 is dead after them
	localparam int unsigned TPA = Y0;
	localparam int unsigned TPB = T0 + 8;

	localparam int unsigned PcW = 7;

	function automatic uinst_t ui(input op_t o, input int a, input int b,
		input int d, input int k);
		uinst_t u;
		u.op = o;
		u.a  = RegW'(a);
		u.b  = RegW'(b);
		u.d  = RegW'(d);
		u.k  = 3'(k);
		return u;
	endfunction

	function automatic uinst_t prog(input logic [PcW-1:0] pc);
		uinst_t u;
		unique case (pc)
			7'd0:   u = ui(OP_ADD, 0, 8, T0+0, 0);
			7'd1:   u = ui(OP_ADD, 1, 9, T0+1, 0);
			7'd2:   u = ui(OP_ADD, 2, 10, T0+2, 0);
			7'd3:   u = ui(OP_ADD, 3, 11, T0+3, 0);
			7'd4:   u = ui(OP_ADD, 4, 12, T0+4, 0);
			7'd5:   u = ui(OP_ADD, 5, 13, T0+5, 0);
			7'd6:   u = ui(OP_ADD, 6, 14, T0+6, 0);
			7'd7:   u = ui(OP_ADD, 7, 15, T0+7, 0);
			7'd8:   u = ui(OP_SUB, 0, 8, T0+8, 0);
			7'd9:   u = ui(OP_SUB, 1, 9, T0+9, 0);
			7'd10:  u = ui(OP_SUB, 2, 10, T0+10, 0);
			7'd11:  u = ui(OP_SUB, 3, 11, T0+11, 0);
			7'd12:  u = ui(OP_SUB, 12, 4, T0+12, 0);
			7'd13:  u = ui(OP_SUB, 13, 5, T0+13, 0);
			7'd14:  u = ui(OP_SUB, 14, 6, T0+14, 0);
			7'd15:  u = ui(OP_SUB, 15, 7, T0+15, 0);
			// complex twiddles
			7'd16:  u = ui(OP_SUB, T0+13, T0+9, TPA, 0);
			7'd17:  u = ui(OP_MULK, TPA, 0, TPA, KS2);
			7'd18:  u = ui(OP_MULK, T0+9, 0, T0+9, KCP);
			7'd19:  u = ui(OP_ADD, T0+9, TPA, T0+9, 0);
			7'd20:  u = ui(OP_MULK, T0+13, 0, T0+13, KM2);
			7'd21:  u = ui(OP_ADD, T0+13, TPA, T0+13, 0);
			7'd22:  u = ui(OP_MULK, T0+14, 0, T0+14, KS4);
			7'd23:  u = ui(OP_MULK, T0+10, 0, T0+10, KS4);
			7'd24:  u = ui(OP_SUB, T0+14, T0+10, T0+14, 0);
			7'd25:  u = ui(OP_ADD, T0+14, T0+10, TPA, 0);
			7'd26:  u = ui(OP_ADD, TPA, T0+10, T0+10, 0);
			7'd27:  u = ui(OP_SUB, T0+15, T0+11, TPA, 0);
			7'd28:  u = ui(OP_MULK, TPA, 0, TPA, KS6);
			7'd29:  u = ui(OP_MULK, T0+11, 0, T0+11, KCP);
			7'd30:  u = ui(OP_ADD, T0+11, TPA, T0+11, 0);
			7'd31:  u = ui(OP_MULK, T0+15, 0, T0+15, KM6);
			7'd32:  u = ui(OP_ADD, T0+15, TPA, T0+15, 0);
			7'd33:  u = ui(OP_ADD, T0+8, T0+10, T0+8, 0);
			7'd34:  u = ui(OP_SUB2, T0+8, T0+10, T0+10, 0);
			7'd35:  u = ui(OP_ADD, T0+12, T0+14, T0+12, 0);
			7'd36:  u = ui(OP_SUB2, T0+12, T0+14, T0+14, 0);
			7'd37:  u = ui(OP_ADD, T0+9, T0+11, T0+9, 0);
			7'd38:  u = ui(OP_SUB2, T0+9, T0+11, T0+11, 0);
			7'd39:  u = ui(OP_ADD, T0+13, T0+15, T0+13, 0);
			7'd40:  u = ui(OP_SUB2, T0+13, T0+15, T0+15, 0);
			7'd41:  u = ui(OP_ADD, T0+8, T0+9, Y0+1, 0);
			7'd42:  u = ui(OP_SUB, T0+8, T0+9, Y0+7, 0);
			7'd43:  u = ui(OP_ADD, T0+12, T0+13, Y0+9, 0);
			7'd44:  u = ui(OP_SUB, T0+13, T0+12, Y0+15, 0);
			7'd45:  u = ui(OP_ADD, T0+10, T0+15, Y0+5, 0);
			7'd46:  u = ui(OP_SUB, T0+14, T0+11, Y0+13, 0);
			7'd47:  u = ui(OP_SUB, T0+10, T0+15, Y0+3, 0);
			7'd48:  u = ui(OP_NSUB, T0+14, T0+11, Y0+11, 0);
			// 8-point real part
			7'd49:  u = ui(OP_ADD, T0+0, T0+4, T0+0, 0);
			7'd50:  u = ui(OP_SUB2, T0+0, T0+4, T0+4, 0);
			7'd51:  u = ui(OP_ADD, T0+1, T0+5, T0+1, 0);
			7'd52:  u = ui(OP_SUB2, T0+1, T0+5, T0+5, 0);
			7'd53:  u = ui(OP_ADD, T0+2, T0+6, T0+2, 0);
			7'd54:  u = ui(OP_SUB2, T0+2, T0+6, T0+6, 0);
			7'd55:  u = ui(OP_ADD, T0+3, T0+7, T0+3, 0);
			7'd56:  u = ui(OP_SUB2, T0+3, T0+7, T0+7, 0);
			7'd57:  u = ui(OP_ADD, T0+0, T0+2, Y0+0, 0);
			7'd58:  u = ui(OP_SUB, T0+0, T0+2, Y0+4, 0);
			7'd59:  u = ui(OP_ADD, T0+1, T0+3, T0+1, 0);
			7'd60:  u = ui(OP_ADD, T0+3, T0+3, TPB, 0);
			7'd61:  u = ui(OP_SUB, TPB, T0+1, Y0+12, 0);
			7'd62:  u = ui(OP_ADD, Y0+0, T0+1, Y0+0, 0);
			7'd63:  u = ui(OP_SUB2, Y0+0, T0+1, Y0+8, 0);
			7'd64:  u = ui(OP_MULK, T0+5, 0, T0+5, KS4);
			7'd65:  u = ui(OP_MULK, T0+7, 0, T0+7, KS4);
			7'd66:  u = ui(OP_SUB, T0+5, T0+7, T0+5, 0);
			7'd67:  u = ui(OP_ADD, T0+5, T0+7, TPB, 0);
			7'd68:  u = ui(OP_ADD, TPB, T0+7, T0+7, 0);
			7'd69:  u = ui(OP_SUB, T0+6, T0+7, Y0+14, 0);
			7'd70:  u = ui(OP_ADD, T0+5, T0+4, Y0+2, 0);
			7'd71:  u = ui(OP_SUB, T0+4, T0+5, Y0+6, 0);
			7'd72:  u = ui(OP_NSUB, T0+7, T0+6, Y0+10, 0);
			// squared magnitudes: m = y*y, tmp = y'*y', m += tmp
			7'd73:  u = ui(OP_MUL, Y0+1, Y0+1, M0+0, 0);
			7'd74:  u = ui(OP_MUL, Y0+9, Y0+9, TPB, 0);
			7'd75:  u = ui(OP_ADD, M0+0, TPB, M0+0, 0);
			7'd76:  u = ui(OP_MUL, Y0+2, Y0+2, M0+1, 0);
			7'd77:  u = ui(OP_MUL, Y0+10, Y0+10, TPB, 0);
			7'd78:  u = ui(OP_ADD, M0+1, TPB, M0+1, 0);
			7'd79:  u = ui(OP_MUL, Y0+3, Y0+3, M0+2, 0);
			7'd80:  u = ui(OP_MUL, Y0+11, Y0+11, TPB, 0);
			7'd81:  u = ui(OP_ADD, M0+2, TPB, M0+2, 0);
			7'd82:  u = ui(OP_MUL, Y0+4, Y0+4, M0+3, 0);
			7'd83:  u = ui(OP_MUL, Y0+12, Y0+12, TPB, 0);
			7'd84:  u = ui(OP_ADD, M0+3, TPB, M0+3, 0);
			7'd85:  u = ui(OP_MUL, Y0+5, Y0+5, M0+4, 0);
			7'd86:  u = ui(OP_MUL, Y0+13, Y0+13, TPB, 0);
			7'd87:  u = ui(OP_ADD, M0+4, TPB, M0+4, 0);
			7'd88:  u = ui(OP_MUL, Y0+6, Y0+6, M0+5, 0);
			7'd89:  u = ui(OP_MUL, Y0+14, Y0+14, TPB, 0);
			7'd90:  u = ui(OP_ADD, M0+5, TPB, M0+5, 0);
			7'd91:  u = ui(OP_MUL, Y0+7, Y0+7, M0+6, 0);
			7'd92:  u = ui(OP_MUL, Y0+15, Y0+15, TPB, 0);
			7'd93:  u = ui(OP_ADD, M0+6, TPB, M0+6, 0);
			7'd94:  u = ui(OP_MUL, Y0+8, Y0+8, M0+7, 0);
			7'd95:  u = ui(OP_MUL, ZR, ZR, TPB, 0);
			7'd96:  u = ui(OP_ADD, M0+7, TPB, M0+7, 0);
			default: u = ui(OP_END, 0, 0, 0, 0);
		endcase
		return u;
	endfunction

endpackage

FILE: design/sliding_fft16_spectrum_bars.sv
// Channel  | Dir | Handshake           | Payload
// ---------+-----+---------------------+-----------------------------
// sample   | in  | in_valid/in_ready   | sample[9:0]
// result   | out | out_valid/out_ready | mag_0..mag_7, led_mask
// config   | in  | cfg_we              | cfg_data[3:0] threshold_shift
//
// A request taken at one edge runs 97 microcode steps through one shared
// ALU/multiplier, one end step, then a done step that loads the output register
// and shifts the window once the output register is free; out_valid rises with
// that load, and no new request is taken until the sequencer is back in idle.
// Reset clears the window and the sequencer; threshold resets to THR_RESET (11 by default).
// A finished result is held in an output register; the next request is
// taken while it waits, but the next result waits for the register to empty.
module sliding_fft16_spectrum_bars #(
	parameter logic [sfb_pkg::ThrW-1:0] THR_RESET = sfb_pkg::ThrReset
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [9:0]  sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] mag_0,
	output logic [15:0] mag_1,
	output logic [15:0] mag_2,
	output logic [15:0] mag_3,
	output logic [15:0] mag_4,
	output logic [15:0] mag_5,
	output logic [15:0] mag_6,
	output logic [15:0] mag_7,
	output logic [7:0]  led_mask,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	logic [sfb_pkg::PcW-1:0] pc_q;
	logic [sfb_pkg::SampleW-1:0] samp_q;
	logic [sfb_pkg::ThrW-1:0] thr_q;
	logic [sfb_pkg::DataW-1:0] rf_q [0:31];
	logic [sfb_pkg::DataW-1:0] m_q [0:7];
	logic [sfb_pkg::SampleW-1:0] win_q [0:sfb_pkg::WinDepth-1];
	logic [sfb_pkg::DataW-1:0] mag_q [0:7];
	logic [7:0] mask_q;
	logic out_valid_q;

	sfb_pkg::uinst_t uw;
	logic [sfb_pkg::DataW-1:0] opa, opb, res;
	logic signed [2*sfb_pkg::DataW-1:0] prod;
	logic [7:0] mask_c;
	logic step_wr, wr_rf, wr_m, done_go;

	assign uw = sfb_pkg::prog(pc_q);

	// read operands: window, scratch file, magnitudes, or the zero slot
	always_comb begin
		if (uw.a < sfb_pkg::RegW'(sfb_pkg::WinDepth))
			opa = {6'd0, win_q[uw.a[3:0]]};
		else if (uw.a < sfb_pkg::RegW'(sfb_pkg::M0))
			opa = rf_q[{uw.a[5], uw.a[3:0]}];
		else if (uw.a < sfb_pkg::RegW'(sfb_pkg::ZR))
			opa = m_q[uw.a[2:0]];
		else
			opa = '0;
		if (uw.b < sfb_pkg::RegW'(sfb_pkg::WinDepth))
			opb = {6'd0, win_q[uw.b[3:0]]};
		else if (uw.b < sfb_pkg::RegW'(sfb_pkg::M0))
			opb = rf_q[{uw.b[5], uw.b[3:0]}];
		else if (uw.b < sfb_pkg::RegW'(sfb_pkg::ZR))
			opb = m_q[uw.b[2:0]];
		else
			opb = '0;
	end

	// shared ALU
	always_comb begin
		prod = '0;
		res  = '0;
		unique case (uw.op)
			sfb_pkg::OP_ADD:  res = opa + opb;
			sfb_pkg::OP_SUB:  res = opa - opb;
			sfb_pkg::OP_SUB2: res = opa - opb - opb;
			sfb_pkg::OP_NSUB: res = 16'd0 - opa - opb;
			sfb_pkg::OP_MULK: begin
				prod = $signed(opa) * $signed(sfb_pkg::kval(uw.k));
				res  = prod[sfb_pkg::FracBits +: sfb_pkg::DataW];
			end
			sfb_pkg::OP_MUL: begin
				prod = $signed(opa) * $signed(opb);
				res  = prod[sfb_pkg::FracBits +: sfb_pkg::DataW];
			end
			default: res = '0;
		endcase
	end

	// bar mask from the finished magnitudes
	always_comb begin
		for (int i = 0; i < 8; i++)
			mask_c[7-i] = m_q[i][15] || ((m_q[i] >> thr_q) != '0);
	end

	assign step_wr = (state_q == ST_RUN) && (uw.op != sfb_pkg::OP_END);
	assign wr_rf   = step_wr && (uw.d >= sfb_pkg::RegW'(sfb_pkg::T0)) &&
		(uw.d < sfb_pkg::RegW'(sfb_pkg::M0));
	assign wr_m    = step_wr && (uw.d >= sfb_pkg::RegW'(sfb_pkg::M0)) &&
		(uw.d < sfb_pkg::RegW'(sfb_pkg::ZR));
	assign done_go = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign mag_0 = mag_q[0];
	assign mag_1 = mag_q[1];
	assign mag_2 = mag_q[2];
	assign mag_3 = mag_q[3];
	assign mag_4 = mag_q[4];
	assign mag_5 = mag_q[5];
	assign mag_6 = mag_q[6];
	assign mag_7 = mag_q[7];
	assign led_mask = mask_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= THR_RESET;
		else if (cfg_we)
			thr_q <= cfg_data;
	end

	// sequencer, window and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			samp_q <= '0;
			out_valid_q <= 1'b0;
			mask_q <= '0;
			for (int i = 0; i < 8; i++)
				mag_q[i] <= '0;
			for (int i = 0; i < sfb_pkg::WinDepth; i++)
				win_q[i] <= '0;
		end else begin
			if (done_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					pc_q <= '0;
					if (in_valid) begin
						samp_q <= sample;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (uw.op == sfb_pkg::OP_END)
						state_q <= ST_DONE;
					else
						pc_q <= pc_q + 1'b1;
				end
				ST_DONE: begin
					if (done_go) begin
						for (int i = 0; i < 8; i++)
							mag_q[i] <= m_q[i];
						mask_q <= mask_c;
						for (int i = 0; i < sfb_pkg::WinDepth-1; i++)
							win_q[i] <= win_q[i+1];
						win_q[sfb_pkg::WinDepth-1] <= samp_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// scratch register file write (t and y slots)
	always_ff @(posedge clk) begin
		if (wr_rf)
			rf_q[{uw.d[5], uw.d[3:0]}] <= res;
	end

	// magnitude registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				m_q[i] <= '0;
		end else if (wr_m) begin
			m_q[uw.d[2:0]] <= res;
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> !in_ready) else $error("ready while busy");
	a_pc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && uw.op != sfb_pkg::OP_END |=> pc_q == $past(pc_q) + 1'b1)
		else $error("step counter skipped");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(led_mask))
		else $error("result dropped");
endmodule
